// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DATA_BITS      = 64;   // width of ports and of the config data bus
    localparam int CFG_INDEX_BITS = 2;
    localparam int TUSER_BITS     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = CFG_INDEX_BITS'(1);

    // operation run on the shared bit-serial modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE,   // base mod m, as 1 * base
        OP_MULT,     // result * square
        OP_SQUARE    // square * square, then shift exponent
    } mul_op_t;

    typedef struct packed {
        logic    load;      // capture operands of a new word
        logic    start;     // clear accumulator, select operands
        mul_op_t op;
        logic    step;      // one multiplier bit
        logic    out_load;  // move result to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_last;
    } dp_status_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus on a word stream, square-and-multiply over a
// bit-serial shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)      | tuser (low bit up)
//  ---------+-----+-------------------------+----------------------------
//  s_axis   | in  | base[63:0]              | -
//  m_axis   | out | power[63:0]             | fits_byte, modulus_zero
//  cfg      | in  | 0 modulus, 1 exponent   | -
//
// One word at a time; a modular multiply is a start step (load) then 1 bit/cycle.
// After acceptance the base is reduced mod m, then each exponent bit up to the top
// set bit takes a square, preceded by a multiply when the bit is set. A zero
// modulus sends the word straight to the finish state, skipping the multiplies.
// Reset sets modulus and exponent to 1. A stalled result sits in the output
// register while the next word is already accepted and computed.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]      cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [DATA_BITS-1:0]      s_axis_tdata,   // base[63:0]
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [DATA_BITS-1:0]      m_axis_tdata,   // power[63:0]
    output logic [TUSER_BITS-1:0]     m_axis_tuser    // [0] fits_byte, [1] modulus_zero
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mexp_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_base      (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .power        (m_axis_tdata),
        .fits_byte    (m_axis_tuser[0]),
        .modulus_zero (m_axis_tuser[1])
    );

endmodule

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Config registers, operand registers and a shift-and-add modular multiplier
// that handles one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]      cfg_data,
    input  logic [DATA_BITS-1:0]      in_base,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    output logic [DATA_BITS-1:0]      power,
    output logic                      fits_byte,
    output logic                      modulus_zero
);

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] cfg_mod_reg;
    logic [WORD_BITS-1:0] cfg_exp_reg;

    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS:0]   m2_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] sq_reg;
    logic                 zero_reg;

    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] mand_reg;
    logic [WORD_BITS-1:0] mplier_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    mul_op_t              op_reg;

    logic [DATA_BITS-1:0] power_reg;
    logic                 fits_reg;
    logic                 mz_reg;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] sub1;
    logic [WORD_BITS+1:0] sub2;
    logic [WORD_BITS-1:0] acc_next;
    logic                 mul_last;
    logic [DATA_BITS-1:0] res_ext;

    // 2*acc + bit*mand is below 3m: subtract 0, m or 2m
    always_comb begin
        sum  = {1'b0, acc_reg, 1'b0}
             + (mplier_reg[WORD_BITS-1] ? {2'b00, mand_reg} : '0);
        sub1 = sum - {2'b00, m_reg};
        sub2 = sum - {1'b0, m2_reg};
        if (sum >= {1'b0, m2_reg}) begin
            acc_next = sub2[WORD_BITS-1:0];
        end else if (sum >= {2'b00, m_reg}) begin
            acc_next = sub1[WORD_BITS-1:0];
        end else begin
            acc_next = sum[WORD_BITS-1:0];
        end
    end

    assign mul_last = (cnt_reg == CNT_LAST);
    assign res_ext  = DATA_BITS'(res_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mod_reg <= WORD_BITS'(1);
            cfg_exp_reg <= WORD_BITS'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODULUS:  cfg_mod_reg <= cfg_data[WORD_BITS-1:0];
                REG_EXPONENT: cfg_exp_reg <= cfg_data[WORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= cfg_mod_reg;
            m2_reg   <= {cfg_mod_reg, 1'b0};
            e_reg    <= cfg_exp_reg;
            base_reg <= in_base[WORD_BITS-1:0];
            zero_reg <= (cfg_mod_reg == '0);
            // 1 mod m
            res_reg  <= (cfg_mod_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        end

        if (cmd.start) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            op_reg  <= cmd.op;
            unique case (cmd.op)
                OP_REDUCE: begin
                    mand_reg   <= WORD_BITS'(1);
                    mplier_reg <= base_reg;
                end
                OP_MULT: begin
                    mand_reg   <= res_reg;
                    mplier_reg <= sq_reg;
                end
                default: begin
                    mand_reg   <= sq_reg;
                    mplier_reg <= sq_reg;
                end
            endcase
        end else if (cmd.step) begin
            acc_reg    <= acc_next;
            mplier_reg <= {mplier_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg    <= cnt_reg + CNT_BITS'(1);
            if (mul_last) begin
                unique case (op_reg)
                    OP_MULT: res_reg <= acc_next;
                    OP_SQUARE: begin
                        sq_reg <= acc_next;
                        e_reg  <= e_reg >> 1;
                    end
                    default: sq_reg <= acc_next;
                endcase
            end
        end

        if (cmd.out_load) begin
            power_reg <= zero_reg ? '0 : res_ext;
            fits_reg  <= !zero_reg && (res_ext < DATA_BITS'(256));
            mz_reg    <= zero_reg;
        end
    end

    assign status.cfg_mod_zero = (cfg_mod_reg == '0);
    assign status.exp_zero     = (e_reg == '0);
    assign status.exp_lsb      = e_reg[0];
    assign status.mul_last     = mul_last;

    assign power        = power_reg;
    assign fits_byte    = fits_reg;
    assign modulus_zero = mz_reg;

endmodule

// ===== rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply and the stream handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_START,
        ST_MUL,
        ST_SQ_START,
        ST_NEXT,
        ST_FINISH
    } state_t;

    state_t  state_reg;
    mul_op_t op_reg;
    logic    m_valid_reg;
    logic    out_free;
    logic    accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.op       = OP_REDUCE;
        cmd.load     = accept;
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
        unique case (state_reg)
            ST_RED_START: begin
                cmd.start = 1'b1;
                cmd.op    = OP_REDUCE;
            end
            ST_SQ_START: begin
                cmd.start = 1'b1;
                cmd.op    = OP_SQUARE;
            end
            ST_NEXT: begin
                cmd.start = !status.exp_zero;
                cmd.op    = status.exp_lsb ? OP_MULT : OP_SQUARE;
            end
            ST_MUL: cmd.step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_REDUCE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= status.cfg_mod_zero ? ST_FINISH : ST_RED_START;
                    end
                end
                ST_RED_START: begin
                    op_reg    <= OP_REDUCE;
                    state_reg <= ST_MUL;
                end
                ST_SQ_START: begin
                    op_reg    <= OP_SQUARE;
                    state_reg <= ST_MUL;
                end
                ST_NEXT: begin
                    if (status.exp_zero) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        op_reg    <= status.exp_lsb ? OP_MULT : OP_SQUARE;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (status.mul_last) begin
                        state_reg <= (op_reg == OP_MULT) ? ST_SQ_START : ST_NEXT;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
